// File: src/fpr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fpr_pkg;

    localparam int PAGE_BYTES  = 256;
    localparam int FRAME_BYTES = 262;
    localparam int HDR_BYTES   = 2;
    localparam int CRC_BYTES   = 4;

    localparam logic [11:0] PAGE_BASE_RESET = 12'd512;
    localparam logic [31:0] CRC_POLY        = 32'hEDB88320;

    localparam logic [7:0] CH_B = 8'h42;
    localparam logic [7:0] CH_L = 8'h4C;
    localparam logic [7:0] CH_O = 8'h4F;
    localparam logic [7:0] CH_K = 8'h4B;
    localparam logic [7:0] CH_W = 8'h57;
    localparam logic [7:0] CH_R = 8'h52;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_SECOND = 3'd1,
        PH_DROP   = 3'd2,
        PH_FRAME  = 3'd3,
        PH_FIN    = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        RC_LD = 3'd0,
        RC_DC = 3'd1,
        RC_BC = 3'd2,
        RC_OK = 3'd3,
        RC_ER = 3'd4
    } t_reply;

    typedef enum logic {
        KIND_PAGE  = 1'b0,
        KIND_REPLY = 1'b1
    } t_kind;

    // reflected crc-32, one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

    // crc after the two header bytes
    localparam logic [31:0] CRC_AFTER_HDR = crc_byte(crc_byte(32'hFFFFFFFF, CH_W), CH_R);

endpackage

`default_nettype wire

// File: src/firmware_page_receiver.sv
// firmware page receiver
// input stream: one received byte per request, tdata = data_byte, tuser = chunk_start,
// tlast = chunk_end. while no frame is open the first two bytes of a chunk are a command
// (BL, OK, WR); a WR frame carries the header, one page and a little-endian crc-32.
// output stream: tuser = result kind (0 page byte, 1 reply). page bytes go out with
// their offset and page number as they arrive; replies carry LD, DC, BC, OK or ER.
// page_base is written over apb at any address with bit 2 clear; the user must write it
// only while the block is idle; the block does not enforce this. a byte accepted into the
// input register is processed from there and its result is registered on the output
// register. one byte per cycle while not stalled; the crc byte update is the longest path.
// bytes with no result leave the input register without touching the output.
// when the output is stalled the input register holds and tready drops once it is full;
// a result stays on the output until taken.
// after reset: no frame open, page count zero, page_base 512, not finished. once the
// done command is seen all further bytes are consumed silently until the next reset.
`timescale 1ns / 1ps
`default_nettype none

module firmware_page_receiver (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  wire logic        i_s_tuser,   // [0] chunk_start
    input  wire logic        i_s_tlast,   // chunk_end
    // output stream
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [31:0]      o_m_tdata,   // [7:0] page_byte, [15:8] byte_offset,
                                          // [27:16] page_number, [30:28] reply_code,
                                          // [31] finished
    output logic             o_m_tuser,   // [0] result_kind
    // configuration
    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic [2:0]  i_paddr,
    input  wire logic [31:0] i_pwdata,
    output logic [31:0]      o_prdata,
    output logic             o_pready
);

    localparam logic [8:0] POS_CRC  = 9'(fpr_pkg::FRAME_BYTES - fpr_pkg::CRC_BYTES);
    localparam logic [8:0] POS_LAST = 9'(fpr_pkg::FRAME_BYTES - 1);
    localparam logic [8:0] POS_HDR  = 9'(fpr_pkg::HDR_BYTES);
    localparam logic [8:0] POS_PEND = 9'(fpr_pkg::HDR_BYTES + fpr_pkg::PAGE_BYTES);

    // input register
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_start;
    logic        r_in_end;
    logic        w_advance;

    // block state
    fpr_pkg::t_phase r_phase, n_phase;
    logic [7:0]  r_held, n_held;
    logic [8:0]  r_pos, n_pos;
    logic [31:0] r_crc, n_crc;
    logic [31:0] r_rcv, n_rcv;
    logic [11:0] r_pages, n_pages;
    logic [11:0] r_page_base;

    // output register
    logic        r_out_valid;
    logic        r_out_kind;
    logic [7:0]  r_out_byte, n_out_byte;
    logic [7:0]  r_out_off, n_out_off;
    logic [11:0] r_out_page, n_out_page;
    logic [2:0]  r_out_code, n_out_code;
    logic        r_out_fin, n_out_fin;
    logic        n_emit;
    fpr_pkg::t_kind n_out_kind;

    logic [11:0] w_cur_page;
    logic [31:0] w_rcv_full;

    assign w_advance  = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_advance;
    assign w_cur_page = r_page_base + r_pages;
    assign w_rcv_full = {r_in_byte, r_rcv[31:8]};

    // configuration port
    assign o_pready = 1'b1;
    assign o_prdata = {20'd0, r_page_base};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_base <= fpr_pkg::PAGE_BASE_RESET;
        end else if (i_psel && i_penable && i_pwrite && (i_paddr[2] == 1'b0)) begin
            r_page_base <= i_pwdata[11:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte  <= i_s_tdata;
            r_in_start <= i_s_tuser;
            r_in_end   <= i_s_tlast;
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_held     = r_held;
        n_pos      = r_pos;
        n_crc      = r_crc;
        n_rcv      = r_rcv;
        n_pages    = r_pages;
        n_emit     = 1'b0;
        n_out_kind = fpr_pkg::KIND_REPLY;
        n_out_byte = 8'd0;
        n_out_off  = 8'd0;
        n_out_page = w_cur_page;
        n_out_code = fpr_pkg::RC_LD;
        n_out_fin  = 1'b0;

        // any byte while idle, or a chunk start in the second or drop phase, is a command's first byte
        if ((r_phase == fpr_pkg::PH_IDLE)
            || (((r_phase == fpr_pkg::PH_SECOND) || (r_phase == fpr_pkg::PH_DROP))
                && r_in_start)) begin
            n_held = r_in_byte;
            if (r_in_end) begin
                n_phase    = fpr_pkg::PH_IDLE;
                n_emit     = 1'b1;
                n_out_code = fpr_pkg::RC_BC;
            end else begin
                n_phase = fpr_pkg::PH_SECOND;
            end
        end else begin
            unique case (r_phase)
                fpr_pkg::PH_SECOND: begin
                    if (r_held == fpr_pkg::CH_B && r_in_byte == fpr_pkg::CH_L) begin
                        n_phase    = r_in_end ? fpr_pkg::PH_IDLE : fpr_pkg::PH_DROP;
                        n_emit     = 1'b1;
                        n_out_code = fpr_pkg::RC_LD;
                    end else if (r_held == fpr_pkg::CH_O && r_in_byte == fpr_pkg::CH_K) begin
                        n_phase    = fpr_pkg::PH_FIN;
                        n_emit     = 1'b1;
                        n_out_code = fpr_pkg::RC_DC;
                        n_out_fin  = 1'b1;
                    end else if (r_held == fpr_pkg::CH_W && r_in_byte == fpr_pkg::CH_R) begin
                        n_crc   = fpr_pkg::CRC_AFTER_HDR;
                        n_rcv   = 32'd0;
                        n_pos   = POS_HDR;
                        n_phase = fpr_pkg::PH_FRAME;
                    end else begin
                        n_phase    = r_in_end ? fpr_pkg::PH_IDLE : fpr_pkg::PH_DROP;
                        n_emit     = 1'b1;
                        n_out_code = fpr_pkg::RC_BC;
                    end
                end
                fpr_pkg::PH_DROP: begin
                    if (r_in_end) begin
                        n_phase = fpr_pkg::PH_IDLE;
                    end
                end
                fpr_pkg::PH_FRAME: begin
                    if (r_pos < POS_CRC) begin
                        n_crc = fpr_pkg::crc_byte(r_crc, r_in_byte);
                        n_pos = r_pos + 9'd1;
                        if (r_pos >= POS_HDR && r_pos < POS_PEND) begin
                            n_emit     = 1'b1;
                            n_out_kind = fpr_pkg::KIND_PAGE;
                            n_out_byte = r_in_byte;
                            n_out_off  = 8'(r_pos - POS_HDR);
                        end
                    end else if (r_pos < POS_LAST) begin
                        // crc arrives least significant byte first
                        n_rcv = w_rcv_full;
                        n_pos = r_pos + 9'd1;
                    end else begin
                        n_emit = 1'b1;
                        if (~r_crc == w_rcv_full) begin
                            n_out_code = fpr_pkg::RC_OK;
                            n_pages    = r_pages + 12'd1;
                        end else begin
                            n_out_code = fpr_pkg::RC_ER;
                        end
                        n_pos   = 9'd0;
                        n_crc   = 32'hFFFFFFFF;
                        n_rcv   = 32'd0;
                        n_phase = r_in_end ? fpr_pkg::PH_IDLE : fpr_pkg::PH_DROP;
                    end
                end
                default: begin
                    // finished: bytes are consumed and ignored
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= fpr_pkg::PH_IDLE;
            r_held  <= 8'd0;
            r_pos   <= 9'd0;
            r_crc   <= 32'hFFFFFFFF;
            r_rcv   <= 32'd0;
            r_pages <= 12'd0;
        end else if (w_advance) begin
            r_phase <= n_phase;
            r_held  <= n_held;
            r_pos   <= n_pos;
            r_crc   <= n_crc;
            r_rcv   <= n_rcv;
            r_pages <= n_pages;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && n_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && n_emit) begin
            r_out_kind <= n_out_kind;
            r_out_byte <= n_out_byte;
            r_out_off  <= n_out_off;
            r_out_page <= n_out_page;
            r_out_code <= n_out_code;
            r_out_fin  <= n_out_fin;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_kind;
    assign o_m_tdata  = {r_out_fin, r_out_code, r_out_page, r_out_off, r_out_byte};

    a_fin_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == fpr_pkg::PH_FIN |=> r_phase == fpr_pkg::PH_FIN)
        else $error("finished state left without reset");

    a_frame_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == fpr_pkg::PH_FRAME |-> (r_pos >= POS_HDR && r_pos <= POS_LAST))
        else $error("frame position out of range");

    a_fin_is_dc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && r_out_fin |-> (r_out_kind && r_out_code == fpr_pkg::RC_DC))
        else $error("finished flag on a result other than the done reply");

    a_no_out_after_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == fpr_pkg::PH_FIN && w_advance |-> !n_emit)
        else $error("result produced after finished");

endmodule

`default_nettype wire

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam logic [2:0] REG_PAGE_BASE = 3'd0;
    localparam int SETTLE_CYCLES  = 8;
    localparam int STALL_LIMIT    = 4000;
    localparam int RANDOM_ITEMS   = 600;
    localparam int MAX_MSG_LINES  = 40;

    typedef struct packed {
        fpr_pkg::t_kind  kind;
        logic [7:0]      pbyte;
        logic [7:0]      offset;
        logic [11:0]     page;
        fpr_pkg::t_reply code;
        logic            fin;
    } t_rx_result;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata = 8'd0;
    logic        s_tuser = 1'b0;
    logic        s_tlast = 1'b0;
    logic        m_tready = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    wire         o_s_tready;
    wire         o_m_tvalid;
    wire [31:0]  o_m_tdata;
    wire         o_m_tuser;
    wire [31:0]  o_prdata;
    wire         o_pready;

    // receiver state as the block should hold it
    logic [11:0]     pg_base = fpr_pkg::PAGE_BASE_RESET;
    fpr_pkg::t_phase ph = fpr_pkg::PH_IDLE;
    logic [7:0]      held = 8'd0;
    logic [8:0]      fpos = 9'd0;
    logic [31:0]     crc_run = 32'hFFFFFFFF;
    logic [31:0]     crc_rx = 32'd0;
    logic [11:0]     pages = 12'd0;

    t_rx_result  rx_results_due[$];
    bit          done_allowed = 1'b0;
    int          burst_left = 0;
    int          n_sent = 0;
    int          n_fail = 0;
    int          n_page_bytes = 0;
    int          n_replies = 0;
    int          n_commit = 0;
    int          n_discard = 0;
    int          idle_cycles = 0;
    int          seg_left = 0;
    int          stall_mode = 0;

    firmware_page_receiver dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .i_psel     (psel),
        .i_penable  (penable),
        .i_pwrite   (pwrite),
        .i_paddr    (paddr),
        .i_pwdata   (pwdata),
        .o_prdata   (o_prdata),
        .o_pready   (o_pready)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // bit-serial reflected crc-32, lsb first
    function automatic logic [31:0] crc32_update(input logic [31:0] c, input logic [7:0] d);
        logic [31:0] r;
        r = c;
        for (int k = 0; k < 8; k++) begin
            if (r[0] ^ d[k]) begin
                r = (r >> 1) ^ fpr_pkg::CRC_POLY;
            end else begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

    function automatic void push_result(input fpr_pkg::t_kind kind, input logic [7:0] pbyte,
                                        input logic [7:0] offset, input logic [11:0] page,
                                        input fpr_pkg::t_reply code);
        t_rx_result r;
        r.kind   = kind;
        r.pbyte  = pbyte;
        r.offset = offset;
        r.page   = page;
        r.code   = code;
        r.fin    = (ph == fpr_pkg::PH_FIN);
        rx_results_due.push_back(r);
    endfunction

    function automatic void take_first_byte(input logic [7:0] b, input logic en,
                                            input logic [11:0] pn);
        held = b;
        if (en) begin
            ph = fpr_pkg::PH_IDLE;
            push_result(fpr_pkg::KIND_REPLY, 8'd0, 8'd0, pn, fpr_pkg::RC_BC);
        end else begin
            ph = fpr_pkg::PH_SECOND;
        end
    endfunction

    function automatic void receiver_take_byte(input logic [7:0] b, input logic st,
                                               input logic en);
        logic [11:0]     pn;
        fpr_pkg::t_reply code;
        int              p;
        pn = pg_base + pages;
        p = fpos;
        case (ph)
            fpr_pkg::PH_FIN: begin
            end
            fpr_pkg::PH_SECOND: begin
                if (st) begin
                    take_first_byte(b, en, pn);
                end else if (held == fpr_pkg::CH_B && b == fpr_pkg::CH_L) begin
                    if (en) ph = fpr_pkg::PH_IDLE; else ph = fpr_pkg::PH_DROP;
                    push_result(fpr_pkg::KIND_REPLY, 8'd0, 8'd0, pn, fpr_pkg::RC_LD);
                end else if (held == fpr_pkg::CH_O && b == fpr_pkg::CH_K) begin
                    ph = fpr_pkg::PH_FIN;
                    push_result(fpr_pkg::KIND_REPLY, 8'd0, 8'd0, pn, fpr_pkg::RC_DC);
                end else if (held == fpr_pkg::CH_W && b == fpr_pkg::CH_R) begin
                    crc_run = crc32_update(crc32_update(32'hFFFFFFFF, held), b);
                    crc_rx = 32'd0;
                    fpos = 9'(fpr_pkg::HDR_BYTES);
                    ph = fpr_pkg::PH_FRAME;
                end else begin
                    if (en) ph = fpr_pkg::PH_IDLE; else ph = fpr_pkg::PH_DROP;
                    push_result(fpr_pkg::KIND_REPLY, 8'd0, 8'd0, pn, fpr_pkg::RC_BC);
                end
            end
            fpr_pkg::PH_DROP: begin
                if (st) begin
                    take_first_byte(b, en, pn);
                end else if (en) begin
                    ph = fpr_pkg::PH_IDLE;
                end
            end
            fpr_pkg::PH_FRAME: begin
                if (p < fpr_pkg::FRAME_BYTES - fpr_pkg::CRC_BYTES) begin
                    crc_run = crc32_update(crc_run, b);
                    fpos = 9'(p + 1);
                    if (p >= fpr_pkg::HDR_BYTES
                        && p - fpr_pkg::HDR_BYTES < fpr_pkg::PAGE_BYTES) begin
                        push_result(fpr_pkg::KIND_PAGE, b, 8'(p - fpr_pkg::HDR_BYTES), pn,
                                    fpr_pkg::RC_LD);
                    end
                end else begin
                    // crc arrives least significant byte first
                    crc_rx = crc_rx | ({24'd0, b}
                             << (8 * (p - (fpr_pkg::FRAME_BYTES - fpr_pkg::CRC_BYTES))));
                    if (p < fpr_pkg::FRAME_BYTES - 1) begin
                        fpos = 9'(p + 1);
                    end else begin
                        if (~crc_run == crc_rx) begin
                            code = fpr_pkg::RC_OK;
                            pages = pages + 12'd1;
                        end else begin
                            code = fpr_pkg::RC_ER;
                        end
                        fpos = 9'd0;
                        crc_run = 32'hFFFFFFFF;
                        crc_rx = 32'd0;
                        if (en) ph = fpr_pkg::PH_IDLE; else ph = fpr_pkg::PH_DROP;
                        push_result(fpr_pkg::KIND_REPLY, 8'd0, 8'd0, pn, code);
                    end
                end
            end
            default: begin
                take_first_byte(b, en, pn);
            end
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        if (n_fail < MAX_MSG_LINES) begin
            $display("mismatch at %0t ns: %s", $time, msg);
        end
        n_fail++;
    endtask

    // output checker
    always @(posedge clk) begin
        t_rx_result e;
        if (rst_n && o_m_tvalid && m_tready) begin
            if (rx_results_due.size() == 0) begin
                report_mismatch($sformatf("result with nothing expected, tdata %h tuser %b",
                                          o_m_tdata, o_m_tuser));
            end else begin
                e = rx_results_due.pop_front();
                if (o_m_tuser !== e.kind)
                    report_mismatch($sformatf("kind %b, expected %b", o_m_tuser, e.kind));
                if (o_m_tdata[7:0] !== e.pbyte)
                    report_mismatch($sformatf("page byte %h, expected %h",
                                              o_m_tdata[7:0], e.pbyte));
                if (o_m_tdata[15:8] !== e.offset)
                    report_mismatch($sformatf("offset %0d, expected %0d",
                                              o_m_tdata[15:8], e.offset));
                if (o_m_tdata[27:16] !== e.page)
                    report_mismatch($sformatf("page number %0d, expected %0d",
                                              o_m_tdata[27:16], e.page));
                if (o_m_tdata[30:28] !== e.code)
                    report_mismatch($sformatf("reply code %0d, expected %0d",
                                              o_m_tdata[30:28], e.code));
                if (o_m_tdata[31] !== e.fin)
                    report_mismatch($sformatf("finished %b, expected %b",
                                              o_m_tdata[31], e.fin));
                if (e.kind == fpr_pkg::KIND_PAGE) begin
                    n_page_bytes++;
                end else begin
                    n_replies++;
                    if (e.code == fpr_pkg::RC_OK) n_commit++;
                    if (e.code == fpr_pkg::RC_ER) n_discard++;
                end
            end
        end
    end

    // watchdog on cycles with no transfer of any kind
    always @(posedge clk) begin
        if ((s_tvalid && o_s_tready) || (o_m_tvalid && m_tready) ||
            (psel && penable && o_pready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", idle_cycles);
                $display("FAILURE");
                $finish;
            end
        end
    end

    // receiver back-pressure in segments: free running, coin toss, or mostly stalled
    always @(negedge clk) begin
        if (seg_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            seg_left = $urandom_range(10, 150);
        end
        seg_left--;
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    task automatic send_byte(input logic [7:0] b, input logic st, input logic en);
        int gap;
        logic [7:0] v;
        v = b;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                                     : $urandom_range(1, 30);
            if (gap != 0) begin
                @(negedge clk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        // keep stray traffic from spelling the done command
        if (!done_allowed && ph == fpr_pkg::PH_SECOND && !st && held == fpr_pkg::CH_O
            && v == fpr_pkg::CH_K) begin
            v = ~fpr_pkg::CH_K;
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tuser  <= st;
        s_tlast  <= en;
        receiver_take_byte(v, st, en);
        n_sent++;
        @(posedge clk);
        while (!o_s_tready) @(posedge clk);
    endtask

    task automatic send_command(input logic [7:0] c0, input logic [7:0] c1, input int extra);
        send_byte(c0, 1'b1, 1'b0);
        send_byte(c1, 1'b0, extra == 0);
        for (int i = 0; i < extra; i++) begin
            send_byte(8'($urandom), 1'b0, i == extra - 1);
        end
    endtask

    task automatic send_frame(input bit bad_crc, input int tail, input bit tail_end,
                              input bit split);
        logic [7:0]  fr[fpr_pkg::FRAME_BYTES];
        logic [31:0] crc;
        logic        st;
        logic        en;
        fr[0] = fpr_pkg::CH_W;
        fr[1] = fpr_pkg::CH_R;
        for (int i = fpr_pkg::HDR_BYTES; i < fpr_pkg::FRAME_BYTES - fpr_pkg::CRC_BYTES; i++)
            fr[i] = 8'($urandom);
        fr[fpr_pkg::HDR_BYTES] = 8'h00;
        fr[fpr_pkg::HDR_BYTES + fpr_pkg::PAGE_BYTES - 1] = 8'hFF;
        crc = 32'hFFFFFFFF;
        for (int i = 0; i < fpr_pkg::FRAME_BYTES - fpr_pkg::CRC_BYTES; i++)
            crc = crc32_update(crc, fr[i]);
        crc = ~crc;
        if (bad_crc) crc = crc ^ (32'd1 << $urandom_range(0, 31));
        for (int k = 0; k < fpr_pkg::CRC_BYTES; k++)
            fr[fpr_pkg::FRAME_BYTES - fpr_pkg::CRC_BYTES + k] = crc[8*k +: 8];
        for (int i = 0; i < fpr_pkg::FRAME_BYTES; i++) begin
            // chunk marks inside the frame should make no difference
            st = (i == 0) || (split && i >= fpr_pkg::HDR_BYTES && $urandom_range(0, 31) == 0);
            if (i == fpr_pkg::FRAME_BYTES - 1) begin
                en = (tail == 0) && tail_end;
            end else begin
                en = split && i >= fpr_pkg::HDR_BYTES && $urandom_range(0, 31) == 0;
            end
            send_byte(fr[i], st, en);
        end
        for (int i = 0; i < tail; i++) begin
            send_byte(8'($urandom), 1'b0, tail_end && i == tail - 1);
        end
    endtask

    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (rx_results_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_page_base(input logic [11:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_PAGE_BASE;
        pwdata  <= {20'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!o_pready) @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        pg_base = value;
    endtask

    // commands at the reset page base
    task automatic test_commands();
        send_command(fpr_pkg::CH_B, fpr_pkg::CH_L, 0);
        send_command(fpr_pkg::CH_B, fpr_pkg::CH_L, 2);
        send_command(fpr_pkg::CH_L, fpr_pkg::CH_B, 0);
        send_byte(8'h00, 1'b1, 1'b1);
        send_byte(8'hFF, 1'b1, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b1);
        // first byte with no chunk start
        send_byte(fpr_pkg::CH_B, 1'b0, 1'b0);
        send_byte(fpr_pkg::CH_L, 1'b0, 1'b1);
        // held byte dropped by a new chunk
        send_byte(fpr_pkg::CH_W, 1'b1, 1'b0);
        send_byte(fpr_pkg::CH_B, 1'b1, 1'b0);
        send_byte(fpr_pkg::CH_L, 1'b0, 1'b1);
        // dropped rest of a chunk ended by a chunk start
        send_byte(fpr_pkg::CH_B, 1'b1, 1'b0);
        send_byte(fpr_pkg::CH_L, 1'b0, 1'b0);
        send_byte(8'h5A, 1'b0, 1'b0);
        send_byte(fpr_pkg::CH_O, 1'b1, 1'b1);
        send_command(fpr_pkg::CH_O, fpr_pkg::CH_B, 0);
        send_command(fpr_pkg::CH_W, fpr_pkg::CH_W, 0);
        settle();
    endtask

    // frames at the top page base, so the page number wraps
    task automatic test_frames();
        write_page_base(12'hFFF);
        send_frame(1'b0, 2, 1'b1, 1'b1);
        send_frame(1'b1, 0, 1'b1, 1'b0);
        send_frame(1'b0, 3, 1'b0, 1'b0);
        send_command(fpr_pkg::CH_B, fpr_pkg::CH_L, 0);
        settle();
    endtask

    task automatic test_random_traffic();
        int start;
        int pick;
        int len;
        logic [7:0] c0;
        logic [7:0] c1;
        for (int round = 0; round < 2; round++) begin
            write_page_base(12'($urandom_range(0, 4095)));
            start = n_sent;
            while (n_sent - start < RANDOM_ITEMS / 2) begin
                pick = $urandom_range(0, 99);
                if (pick < 35
                    && (n_sent - start) + fpr_pkg::FRAME_BYTES + 4 <= RANDOM_ITEMS / 2) begin
                    send_frame($urandom_range(0, 5) == 0,
                               ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0,
                               $urandom_range(0, 3) != 0, 1'($urandom_range(0, 1)));
                end else if (pick < 55) begin
                    case ($urandom_range(0, 3))
                        0:       c0 = fpr_pkg::CH_B;
                        1:       c0 = fpr_pkg::CH_O;
                        2:       c0 = fpr_pkg::CH_W;
                        default: c0 = 8'($urandom);
                    endcase
                    case ($urandom_range(0, 3))
                        0:       c1 = fpr_pkg::CH_L;
                        1:       c1 = fpr_pkg::CH_K;
                        2:       c1 = fpr_pkg::CH_R;
                        default: c1 = 8'($urandom);
                    endcase
                    send_command(c0, c1, $urandom_range(0, 3));
                end else if (pick < 75) begin
                    len = $urandom_range(1, 5);
                    for (int i = 0; i < len; i++) begin
                        send_byte(8'($urandom), (i == 0) && ($urandom_range(0, 7) != 0),
                                  (i == len - 1) && ($urandom_range(0, 7) != 0));
                    end
                end else begin
                    send_byte(8'($urandom), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
                end
            end
            // close whatever is open before the register changes
            while (ph == fpr_pkg::PH_FRAME) send_byte(8'($urandom), 1'b0, 1'b1);
            if (ph != fpr_pkg::PH_IDLE) send_byte(8'h00, 1'b1, 1'b1);
            settle();
        end
    endtask

    // done command, then everything must be swallowed
    task automatic test_done_command();
        write_page_base(12'h000);
        send_command(fpr_pkg::CH_B, fpr_pkg::CH_L, 1);
        done_allowed = 1'b1;
        send_command(fpr_pkg::CH_O, fpr_pkg::CH_K, 2);
        send_command(fpr_pkg::CH_B, fpr_pkg::CH_L, 0);
        send_command(fpr_pkg::CH_W, fpr_pkg::CH_R, 0);
        for (int i = 0; i < 20; i++) begin
            send_byte(8'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
        settle();
    endtask

    initial begin
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        test_commands();
        test_frames();
        test_random_traffic();
        test_done_command();
        $display("covered %0d input bytes: commands, good and bad frames, chunk marks, drops",
                 n_sent);
        $display("checked %0d page bytes and %0d replies (%0d pages committed, %0d discarded)",
                 n_page_bytes, n_replies, n_commit, n_discard);
        if (n_fail == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
